// ----- rtl/softmax_threshold_argmax_assert.svh -----
// Assertion macros shared by the RTL files of the softmax classifier.
`ifndef SOFTMAX_THRESHOLD_ARGMAX_ASSERT_SVH
`define SOFTMAX_THRESHOLD_ARGMAX_ASSERT_SVH
`ifndef SYNTHESIS
`define STA_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define STA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define STA_ASSERT(label, clk, rst_n, prop, msg)
`define STA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ----- rtl/sta_pkg.sv -----
// ----------------------------------------------------------------------------
// sta_pkg
// Shared constants, types and the exp2 fraction table of the classifier.
// ----------------------------------------------------------------------------
package sta_pkg;
	localparam int MAX_CLASSES_DEF = 512;
	localparam logic [15:0] THRESHOLD_RST = 16'd655;
	localparam logic [7:0] SKIP_RST = 8'd1;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [12:0] CUTOFF_Q8 = 13'd4096;
	localparam logic [0:0] REQ_FRAME = 1'b0;
	localparam logic [0:0] REG_THRESHOLD = 1'b0;
	localparam logic [0:0] REG_SKIP = 1'b1;

	typedef struct packed {
		logic start_max;
		logic start_sum;
		logic start_div;
	} cmd_t;

	typedef struct packed {
		logic max_done;
		logic sum_done;
		logic div_done;
	} sts_t;

	// 2^(-f/256) in Q1.16, built with the same rounded recurrence as the testbench scoreboard.
	function automatic logic [16:0] exp2_frac(input logic [7:0] f);
		logic [63:0] acc;
		logic [16:0] r;
		acc = 64'h1_0000_0000;
		r = 17'd0;
		for (int i = 0; i < 256; i++) begin
			if (i == int'(f))
				r = 17'((acc + 64'd32768) >> 16);
			acc = (acc * 64'd4283353945 + 64'd2147483648) >> 32;
		end
		return r;
	endfunction
endpackage

// ----- rtl/sta_ctrl.sv -----
// ----------------------------------------------------------------------------
// sta_ctrl
// Sequencer for one classification run: max pass, sum pass, divide.
// ----------------------------------------------------------------------------
module sta_ctrl import sta_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic go,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy,
	output logic done
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MAX  = 2'd1;
	localparam logic [1:0] S_SUM  = 2'd2;
	localparam logic [1:0] S_DIV  = 2'd3;

	logic [1:0] state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (go) state_q <= S_MAX;
				S_MAX: if (sts.max_done) state_q <= S_SUM;
				S_SUM: if (sts.sum_done) state_q <= S_DIV;
				S_DIV: if (sts.div_done) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.start_max = (state_q == S_IDLE) && go;
		cmd.start_sum = (state_q == S_MAX) && sts.max_done;
		cmd.start_div = (state_q == S_SUM) && sts.sum_done;
	end
	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DIV) && sts.div_done;
endmodule

// ----- rtl/sta_dp.sv -----
// ----------------------------------------------------------------------------
// sta_dp
// Logit store, max and exponent-sum passes, and a radix-2 divider.
// ----------------------------------------------------------------------------
`include "softmax_threshold_argmax_assert.svh"
module sta_dp import sta_pkg::*; #(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  logic [15:0] wr_data,
	input  logic [$clog2(MAX_CLASSES+1)-1:0] count,
	input  cmd_t cmd,
	output sts_t sts,
	output logic [9:0] best_idx,
	output logic [16:0] quot
);
	localparam int AW = $clog2(MAX_CLASSES);
	localparam int CW = $clog2(MAX_CLASSES + 1);
	// Every term is at most 2^16, so the sum needs 17 bits above the count width.
	localparam int SW = CW + 17;

	logic signed [15:0] mem [MAX_CLASSES];
	logic [CW-1:0] wr_ptr_q;
	logic [CW-1:0] rd_ptr_q;
	logic signed [15:0] rd_s1;
	logic rd_v_s1;
	logic [CW-1:0] rd_idx_s1;
	logic max_run_q, sum_run_q, div_run_q;
	logic signed [15:0] max_q;
	logic [CW-1:0] best_q;
	logic [16:0] diff_s2;
	logic v_s2;
	logic [33:0] prod_s3;
	logic v_s3;
	logic [16:0] term_s4;
	logic v_s4;
	logic [SW-1:0] sum_q;
	logic [33:0] rem_q;
	logic [32:0] q_q;
	logic [5:0] bit_q;
	logic issue;

	// Writes count up from zero each run; the pointer restarts when a max pass starts.
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_ptr_q[AW-1:0]] <= wr_data;
		rd_s1 <= mem[rd_ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
		end else if (wr_en) begin
			wr_ptr_q <= wr_ptr_q + CW'(1);
		end else if (cmd.start_max) begin
			wr_ptr_q <= '0;
		end
	end

	assign issue = (max_run_q || sum_run_q) && (rd_ptr_q < count);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			rd_v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			max_run_q <= 1'b0;
			sum_run_q <= 1'b0;
			div_run_q <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			v_s2 <= rd_v_s1 && sum_run_q;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cmd.start_max || cmd.start_sum)
				rd_ptr_q <= '0;
			else if (issue)
				rd_ptr_q <= rd_ptr_q + CW'(1);
			if (cmd.start_max)
				max_run_q <= 1'b1;
			else if (sts.max_done)
				max_run_q <= 1'b0;
			if (cmd.start_sum)
				sum_run_q <= 1'b1;
			else if (sts.sum_done)
				sum_run_q <= 1'b0;
			if (cmd.start_div)
				div_run_q <= 1'b1;
			else if (sts.div_done)
				div_run_q <= 1'b0;
		end
	end

	// A pass ends once every read has drained out of its pipeline.
	assign sts.max_done = max_run_q && !issue && !rd_v_s1 && (rd_ptr_q >= count);
	assign sts.sum_done = sum_run_q && !issue && !rd_v_s1 && !v_s2 && !v_s3 && !v_s4
		&& (rd_ptr_q >= count);
	assign sts.div_done = div_run_q && (bit_q == 6'd0);

	always_ff @(posedge clk) begin
		if (cmd.start_max)
			best_q <= '0;
		if (rd_v_s1 && max_run_q) begin
			if (rd_idx_s1 == '0 || rd_s1 > max_q) begin
				max_q <= rd_s1;
				best_q <= rd_idx_s1;
			end
		end
		rd_idx_s1 <= rd_ptr_q;
		diff_s2 <= 17'(signed'({max_q[15], max_q}) - signed'({rd_s1[15], rd_s1}));
		prod_s3 <= (diff_s2 > 17'(CUTOFF_Q8)) ? 34'h3_FFFF_FFFF : diff_s2 * LOG2E_Q16;
		if (prod_s3 == 34'h3_FFFF_FFFF || prod_s3[33:24] > 10'd31)
			term_s4 <= '0;
		else
			term_s4 <= exp2_frac(prod_s3[23:16]) >> prod_s3[28:24];
		if (cmd.start_sum)
			sum_q <= '0;
		else if (v_s4)
			sum_q <= sum_q + SW'(term_s4);
	end

	// One quotient bit per cycle of 2^32 / sum.
	always_ff @(posedge clk) begin
		if (cmd.start_div) begin
			rem_q <= '0;
			q_q <= '0;
			bit_q <= 6'd33;
		end else if (div_run_q && bit_q != 6'd0) begin
			logic [33:0] r;
			r = {rem_q[32:0], (bit_q == 6'd33)};
			if (r >= 34'(sum_q)) begin
				rem_q <= r - 34'(sum_q);
				q_q <= {q_q[31:0], 1'b1};
			end else begin
				rem_q <= r;
				q_q <= {q_q[31:0], 1'b0};
			end
			bit_q <= bit_q - 6'd1;
		end
	end

	assign best_idx = 10'(best_q);
	assign quot = (q_q > 33'd65535) ? 17'd65535 : 17'(q_q);

	`STA_ASSERT(a_one_pass, clk, arst_n, !(max_run_q && sum_run_q), "two passes at once")
	`STA_ASSERT(a_ptr_bound, clk, arst_n, rd_ptr_q <= count || !(max_run_q || sum_run_q),
		"read pointer past count")
	`STA_ASSERT_NEXT(a_sum_floor, clk, arst_n, sts.sum_done && count != '0,
		sum_q >= SW'(65536), "sum below one")
endmodule

// ----- rtl/softmax_threshold_argmax.sv -----
// ----------------------------------------------------------------------------
// softmax_threshold_argmax
// Frame skip decision and fixed-point softmax argmax over stored logits.
// ----------------------------------------------------------------------------
// A frame event or a logit word is taken while in_valid is high and in_stall is
// low. The last logit of a run starts a max pass and an exponent-sum pass over
// the store, one entry per cycle each, then a bit-serial divide; the input
// stalls until the result word of the run shows.
`include "softmax_threshold_argmax_assert.svh"
module softmax_threshold_argmax import sta_pkg::*; #(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic req_type,
	input  logic signed [15:0] logit,
	input  logic last_logit,
	output logic out_valid,
	input  logic out_stall,
	output logic result_kind,
	output logic run_network,
	output logic signed [9:0] class_index,
	output logic [15:0] confidence,
	output logic overflow,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [0:0] cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int CW = $clog2(MAX_CLASSES + 1);

	logic [15:0] thr_q;
	logic [7:0] skip_q;
	logic [CW-1:0] count_q;
	logic [7:0] frames_q;
	logic [9:0] last_class_q;
	logic [15:0] last_conf_q;
	logic ovf_q, run_ovf_q;
	logic go_q;
	logic accept, go, busy, done, wr_en;
	cmd_t cmd;
	sts_t sts;
	logic [9:0] best_idx;
	logic [16:0] quot;

	assign cfg_ready = 1'b1;
	assign in_stall = busy || go_q || (out_valid && out_stall);
	assign accept = in_valid && !in_stall;
	assign wr_en = accept && req_type && (count_q < CW'(MAX_CLASSES));
	assign go = go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RST;
			skip_q <= SKIP_RST;
		end else if (cfg_valid) begin
			if (cfg_index == REG_THRESHOLD) thr_q <= cfg_data;
			else skip_q <= cfg_data[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			frames_q <= 8'd255;
			last_class_q <= '0;
			last_conf_q <= '0;
			ovf_q <= 1'b0;
			run_ovf_q <= 1'b0;
			go_q <= 1'b0;
			out_valid <= 1'b0;
			result_kind <= 1'b0;
			run_network <= 1'b0;
			class_index <= '0;
			confidence <= '0;
			overflow <= 1'b0;
		end else begin
			go_q <= 1'b0;
			if (out_valid && !out_stall)
				out_valid <= 1'b0;
			if (accept && req_type == REQ_FRAME) begin
				out_valid <= 1'b1;
				result_kind <= 1'b0;
				overflow <= 1'b0;
				class_index <= last_class_q;
				confidence <= last_conf_q;
				if (frames_q < skip_q) begin
					frames_q <= frames_q + 8'd1;
					run_network <= 1'b0;
				end else begin
					frames_q <= '0;
					run_network <= 1'b1;
				end
			end else if (accept) begin
				if (wr_en) count_q <= count_q + CW'(1);
				else ovf_q <= 1'b1;
				if (last_logit) begin
					run_ovf_q <= ovf_q || !wr_en;
					ovf_q <= 1'b0;
					if (count_q == '0 && !wr_en) begin
						last_class_q <= 10'h3FF;
						last_conf_q <= '0;
						out_valid <= 1'b1;
						result_kind <= 1'b1;
						run_network <= 1'b0;
						class_index <= 10'h3FF;
						confidence <= '0;
						overflow <= 1'b1;
					end else begin
						go_q <= 1'b1;
					end
				end
			end
			if (done) begin
				count_q <= '0;
				out_valid <= 1'b1;
				result_kind <= 1'b1;
				run_network <= 1'b0;
				overflow <= run_ovf_q;
				if (quot[15:0] < thr_q) begin
					last_class_q <= 10'h3FF;
					last_conf_q <= '0;
					class_index <= 10'h3FF;
					confidence <= '0;
				end else begin
					last_class_q <= best_idx;
					last_conf_q <= quot[15:0];
					class_index <= best_idx;
					confidence <= quot[15:0];
				end
			end
		end
	end

	sta_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .go(go), .sts(sts),
		.cmd(cmd), .busy(busy), .done(done)
	);

	sta_dp #(.MAX_CLASSES(MAX_CLASSES)) u_dp (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .wr_data(logit),
		.count(count_q), .cmd(cmd), .sts(sts), .best_idx(best_idx), .quot(quot)
	);

	`STA_ASSERT(a_no_accept_busy, clk, arst_n, !(accept && busy), "word taken during run")
	`STA_ASSERT_NEXT(a_done_out, clk, arst_n, done, out_valid && result_kind,
		"run result not shown")
	`STA_ASSERT(a_count_max, clk, arst_n, count_q <= CW'(MAX_CLASSES), "count past store")
endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// Softmax classifier testbench
// Drives frame events and logit runs through the classifier, predicts every
// frame decision and classification word and checks them in order, across
// several threshold and skip settings, with random idling on both sides.
// ----------------------------------------------------------------------------
class softmax_scoreboard;
	typedef struct {
		logic kind;
		logic run;
		logic signed [9:0] cls;
		logic [15:0] conf;
		logic ovf;
	} word_t;

	word_t expected_words[$];
	logic [16:0] frac_tab[256];
	logic signed [15:0] store[512];
	int count;
	logic [7:0] skipped;
	logic signed [9:0] held_class;
	logic [15:0] held_conf;
	logic dropped;
	logic [15:0] threshold;
	logic [7:0] skip_limit;
	int mismatches;
	int checked;
	int class_words;
	int rejected;
	int overflow_runs;

	function new();
		logic [63:0] acc;
		acc = 64'h1_0000_0000;
		for (int f = 0; f < 256; f++) begin
			frac_tab[f] = 17'((acc + 64'd32768) >> 16);
			acc = (acc * 64'd4283353945 + 64'd2147483648) >> 32;
		end
		count = 0;
		skipped = 8'd255;
		held_class = '0;
		held_conf = '0;
		dropped = 1'b0;
		threshold = 16'd655;
		skip_limit = 8'd1;
		mismatches = 0;
		checked = 0;
		class_words = 0;
		rejected = 0;
		overflow_runs = 0;
	endfunction

	function void set_reg(logic [0:0] idx, logic [15:0] data);
		if (idx == sta_pkg::REG_THRESHOLD)
			threshold = data;
		else
			skip_limit = data[7:0];
	endfunction

	function logic [31:0] exp_weight(logic [31:0] diff);
		logic [31:0] u;
		if (diff > 32'd4096)
			return 32'd0;
		u = 32'((64'(diff) * 64'd94548) >> 16);
		return 32'(frac_tab[u[7:0]]) >> u[31:8];
	endfunction

	function void note_input(logic req, logic signed [15:0] value, logic last);
		word_t w;
		int best;
		logic signed [15:0] peak;
		logic [63:0] total;
		logic [63:0] conf;
		if (req == sta_pkg::REQ_FRAME) begin
			if (skipped < skip_limit) begin
				skipped = skipped + 8'd1;
				w.run = 1'b0;
			end else begin
				skipped = 8'd0;
				w.run = 1'b1;
			end
			w.kind = 1'b0;
			w.cls = held_class;
			w.conf = held_conf;
			w.ovf = 1'b0;
			expected_words.push_back(w);
			return;
		end
		if (count < 512) begin
			store[count] = value;
			count++;
		end else begin
			dropped = 1'b1;
		end
		if (!last)
			return;
		best = 0;
		peak = store[0];
		for (int n = 1; n < count; n++)
			if (store[n] > peak) begin
				peak = store[n];
				best = n;
			end
		total = '0;
		for (int n = 0; n < count; n++)
			total += 64'(exp_weight(32'(int'(peak) - int'(store[n]))));
		conf = 64'h1_0000_0000 / total;
		if (conf > 64'd65535)
			conf = 64'd65535;
		if (conf < 64'(threshold)) begin
			held_class = -10'sd1;
			held_conf = '0;
			rejected++;
		end else begin
			held_class = 10'(best);
			held_conf = conf[15:0];
		end
		w.kind = 1'b1;
		w.run = 1'b0;
		w.cls = held_class;
		w.conf = held_conf;
		w.ovf = dropped;
		if (dropped)
			overflow_runs++;
		count = 0;
		dropped = 1'b0;
		expected_words.push_back(w);
	endfunction

	function void check_result(logic kind, logic run, logic signed [9:0] cls,
			logic [15:0] conf, logic ovf);
		word_t w;
		checked++;
		if (expected_words.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: kind %0d run %0d class %0d conf %0d ovf %0d",
					kind, run, cls, conf, ovf);
			return;
		end
		w = expected_words.pop_front();
		if (kind)
			class_words++;
		if (kind !== w.kind || run !== w.run || cls !== w.cls || conf !== w.conf ||
				ovf !== w.ovf) begin
			mismatches++;
			if (mismatches <= 10) begin
				$write("mismatch: expected kind %0d run %0d class %0d conf %0d ovf %0d, ",
					w.kind, w.run, w.cls, w.conf, w.ovf);
				$display("got kind %0d run %0d class %0d conf %0d ovf %0d",
					kind, run, cls, conf, ovf);
			end
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import sta_pkg::*;

	localparam int CYCLE_LIMIT = 800000;
	localparam int DRAIN_CYCLES = 1200;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic req_type;
	logic signed [15:0] logit;
	logic last_logit;
	logic out_valid;
	logic out_stall;
	logic result_kind;
	logic run_network;
	logic signed [9:0] class_index;
	logic [15:0] confidence;
	logic overflow;
	logic cfg_valid;
	logic cfg_ready;
	logic [0:0] cfg_index;
	logic [15:0] cfg_data;

	softmax_scoreboard sb;
	int cycles;
	int items_sent;
	bit quiet;
	bit hold_req;

	softmax_threshold_argmax dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .logit(logit), .last_logit(last_logit),
		.out_valid(out_valid), .out_stall(out_stall),
		.result_kind(result_kind), .run_network(run_network),
		.class_index(class_index), .confidence(confidence), .overflow(overflow),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycles);
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result_kind, run_network, class_index, confidence, overflow);

	// Receiver side: random stall bursts, or one long hold when asked.
	initial begin
		int n;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (n = 0; n < 300; n++)
					@(posedge clk);
				hold_req = 0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 4);
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic send_word(logic req, logic signed [15:0] value, logic last);
		req_type <= req;
		logit <= value;
		last_logit <= last;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_input(req, value, last);
		items_sent++;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic send_run(int len, logic signed [15:0] base, int spread);
		logic signed [15:0] v;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 7) == 0)
				v = 16'($urandom);
			else
				v = 16'(int'(base) + $signed($urandom_range(0, 2 * spread)) - spread);
			send_word(1'b1, v, i == len - 1);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, logic [15:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	task automatic random_phase(int n_items);
		int sent;
		int len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 2) == 0) begin
				send_word(REQ_FRAME, 16'($urandom), 1'($urandom));
				sent++;
			end else begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
					: $urandom_range(1, 16);
				send_run(len, 16'($urandom), $urandom_range(0, 3) == 0 ? 4000 : 600);
				sent += len;
			end
		end
	endtask

	initial begin
		sb = new();
		items_sent = 0;
		quiet = 0;
		hold_req = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = 1'b0;
		logit = '0;
		last_logit = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings.
		send_word(REQ_FRAME, 16'sh0000, 1'b0);
		send_word(REQ_FRAME, 16'sh7fff, 1'b1);
		send_word(REQ_FRAME, 16'sh8000, 1'b0);
		send_word(1'b1, 16'sh7fff, 1'b1);                 // single logit
		send_word(1'b1, 16'sh0100, 1'b0);                 // tie picks first
		send_word(1'b1, 16'sh0100, 1'b1);
		send_word(1'b1, 16'sh8000, 1'b0);                 // far below cutoff
		send_word(1'b1, 16'sh7fff, 1'b1);
		send_word(1'b1, 16'sh0000, 1'b0);                 // just at cutoff
		send_word(1'b1, 16'sh1000, 1'b0);
		send_word(1'b1, 16'shefff, 1'b1);
		send_word(REQ_FRAME, 16'sh0000, 1'b0);
		send_word(REQ_FRAME, 16'sh0000, 1'b0);
		wait_idle();
		write_reg(REG_THRESHOLD, 16'hffff);
		write_reg(REG_SKIP, 16'd0);
		send_run(3, 16'sh0000, 0);                        // below threshold
		send_word(REQ_FRAME, 16'sh0000, 1'b0);
		// One longer run with everything reported.
		wait_idle();
		write_reg(REG_THRESHOLD, 16'd0);
		send_run(64, 16'sh0200, 300);
		send_word(REQ_FRAME, 16'sh0000, 1'b0);

		// Random phases over several settings.
		wait_idle();
		write_reg(REG_THRESHOLD, 16'd0);
		write_reg(REG_SKIP, 16'd254);
		random_phase(50);
		wait_idle();
		write_reg(REG_THRESHOLD, 16'hffff);
		write_reg(REG_SKIP, 16'd0);
		random_phase(40);
		wait_idle();
		write_reg(REG_THRESHOLD, 16'($urandom_range(1000, 40000)));
		write_reg(REG_SKIP, 16'($urandom_range(1, 5)));
		random_phase(60);
		// Long receiver hold while frame words keep coming.
		hold_req = 1;
		for (int i = 0; i < 30; i++)
			send_word(REQ_FRAME, 16'($urandom), 1'b0);
		// Sender waits for every outstanding word before going on.
		in_valid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		random_phase(60);
		wait_idle();
		write_reg(REG_THRESHOLD, 16'($urandom));
		write_reg(REG_SKIP, 16'($urandom_range(0, 254)));
		random_phase(60);
		wait_idle();
		quiet = 1;
		write_reg(REG_THRESHOLD, 16'd655);
		write_reg(REG_SKIP, 16'd2);
		random_phase(40);

		wait_idle();
		$display("covered %0d input words, %0d output words, %0d classification words",
			items_sent, sb.checked, sb.class_words);
		$display("%0d runs below threshold, %0d runs with store overflow",
			sb.rejected, sb.overflow_runs);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("%0d mismatches, %0d words missing", sb.mismatches,
				sb.expected_words.size());
			$display("testbench: FAIL");
		end
		$finish;
	end
endmodule
